/* rtl/core/stereo_comb_allpass_delay_unit_defines.svh */
// Assertion macros shared by the delay unit RTL.
`ifndef STEREO_COMB_ALLPASS_DELAY_UNIT_DEFINES_SVH
`define STEREO_COMB_ALLPASS_DELAY_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define SACD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define SACD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sacd_pkg.sv */
// Shared constants, types and helpers of the comb/allpass delay unit.
package sacd_pkg;

    localparam int MaxDelay = 4096;
    localparam int AddrW    = $clog2(MaxDelay);
    localparam int LenW     = AddrW + 1;
    localparam int SampleW  = 16;
    localparam int GainW    = 15;
    localparam int DlenW    = 13;
    localparam int LagW     = 12;
    localparam int CfgW     = 15;
    localparam int CfgAddrW = 2;
    localparam int ProdW    = SampleW + GainW + 1;
    localparam int SumW     = SampleW + 2;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_FILTER_MODE   = 2'd0,
        CFG_DELAY_LENGTH  = 2'd1,
        CFG_READ_LAG      = 2'd2,
        CFG_FEEDBACK_GAIN = 2'd3
    } cfg_idx_t;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;   // latch input beat, clamp length/lag/write pointer
        logic addr;      // form read pointer, advance write pointer
        logic rd;        // delay memory read
        logic mul;       // gain multiply
        logic mul_w;     // multiply the written value instead of the read one
        logic wr;        // delay memory write
        logic load_out;  // load output register
    } sacd_cmd_t;

    function automatic logic signed [SampleW-1:0] sat_sample(
        input logic signed [SumW-1:0] v
    );
        logic signed [SumW-1:0] hi;
        logic signed [SumW-1:0] lo;
        hi = SumW'((1 << (SampleW - 1)) - 1);
        lo = -hi - SumW'(1);
        if (v > hi)
        begin
            return hi[SampleW-1:0];
        end
        else if (v < lo)
        begin
            return lo[SampleW-1:0];
        end
        return v[SampleW-1:0];
    endfunction

endpackage

/* rtl/core/stereo_comb_allpass_delay_unit.sv */
// Top level of the stereo comb/allpass delay unit.
//
//  channel   dir  beat fields (low bit first)
//  s_axis    in   left_sample, right_sample, left_accumulate, right_accumulate
//  m_axis    out  left_result, right_result
//  cfg       in   write only: filter_mode, delay_length, read_lag, feedback_gain
//
// Each frame runs through the steps accept, address, memory read, multiply,
// write, multiply, finish. The per-channel multiplier is used twice and the
// delay memory has a registered read, which sets this sequence.
// A stalled result sits in the output register; the next frame is accepted
// meanwhile and waits in the finish step until the register frees.
// Reset is immediate, no clearing pass: a fill count reads unwritten entries as zero.
module stereo_comb_allpass_delay_unit
    import sacd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // left_sample, right_sample, left_accumulate, right_accumulate
    input  logic [4*SampleW-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // left_result, right_result
    output logic [2*SampleW-1:0] m_axis_tdata,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgW-1:0]     cfg_wdata
);

    sacd_cmd_t                 cmd;
    logic signed [SampleW-1:0] left_result;
    logic signed [SampleW-1:0] right_result;

    sacd_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    sacd_dpath u_dpath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .left_sample      ($signed(s_axis_tdata[SampleW-1:0])),
        .right_sample     ($signed(s_axis_tdata[2*SampleW-1:SampleW])),
        .left_accumulate  ($signed(s_axis_tdata[3*SampleW-1:2*SampleW])),
        .right_accumulate ($signed(s_axis_tdata[4*SampleW-1:3*SampleW])),
        .left_result      (left_result),
        .right_result     (right_result)
    );

    assign m_axis_tdata = {right_result, left_result};

endmodule

/* rtl/core/sacd_ctrl.sv */
// Sequencer of the delay unit: handshakes and datapath commands.
`include "stereo_comb_allpass_delay_unit_defines.svh"

module sacd_ctrl
    import sacd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    output logic      m_axis_tvalid,
    input  logic      m_axis_tready,
    output sacd_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ADDR   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_MUL1   = 7'b0001000,
        ST_WRITE  = 7'b0010000,
        ST_MUL2   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul    = 1'b1;
                cmd.mul_w  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `SACD_ASSERT_NXT(a_accept_starts_item, s_axis_tvalid && s_axis_tready, state_reg == ST_ADDR, "accepted beat did not start the sequence")
    `SACD_ASSERT_IMP(a_result_from_finish, $rose(m_tvalid_reg), $past(state_reg) == ST_FINISH, "result raised outside the finish step")

endmodule

/* rtl/core/sacd_chan.sv */
// One channel: delay memory, shared gain multiplier, saturating adders.
module sacd_chan
    import sacd_pkg::*;
(
    input  logic                      clk,
    input  sacd_cmd_t                 cmd,
    input  logic signed [SampleW-1:0] sample,
    input  logic signed [SampleW-1:0] accumulate,
    input  logic        [GainW-1:0]   gain,
    input  logic                      allpass,
    input  logic        [AddrW-1:0]   rd_addr,
    input  logic        [AddrW-1:0]   wr_addr,
    input  logic                      rd_hit,
    input  logic                      lag_zero,
    output logic signed [SampleW-1:0] result
);

    logic signed [SampleW-1:0] mem [MaxDelay];

    logic signed [SampleW-1:0] x_reg;
    logic signed [SampleW-1:0] acc_reg;
    logic signed [SampleW-1:0] rdata_reg;
    logic                      hit_reg;
    logic signed [ProdW-1:0]   prod_reg;
    logic signed [SampleW-1:0] w_reg;
    logic signed [SampleW-1:0] d_reg;
    logic signed [SampleW-1:0] result_reg;

    logic signed [SampleW-1:0] rd_val;
    logic signed [SampleW-1:0] mul_op;
    logic signed [ProdW-1:0]   prod_next;
    logic signed [ProdW-1:0]   prod_rnd;
    logic signed [ProdW-1:0]   prod_shr;
    logic signed [SampleW:0]   scaled;
    logic signed [SampleW-1:0] w_next;
    logic signed [SampleW-1:0] res_next;

    // unwritten entries read as zero
    assign rd_val  = hit_reg ? rdata_reg : '0;
    assign mul_op  = cmd.mul_w ? w_reg : rd_val;
    assign prod_next = $signed(ProdW'(mul_op) * ProdW'({1'b0, gain}));

    // round half up to one sample LSB
    assign prod_rnd = prod_reg + ProdW'(1 << (GainW - 1));
    assign prod_shr = prod_rnd >>> GainW;
    assign scaled   = prod_shr[SampleW:0];

    assign w_next = sat_sample(SumW'(x_reg) + SumW'(scaled));
    assign res_next = allpass ? sat_sample(SumW'(d_reg) - SumW'(scaled))
                              : sat_sample(SumW'(acc_reg) + SumW'(d_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.wr)
        begin
            mem[wr_addr] <= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg   <= sample;
            acc_reg <= accumulate;
        end
        if (cmd.rd)
        begin
            hit_reg <= rd_hit;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.wr)
        begin
            w_reg <= w_next;
            // second read sees the new entry only when read and write coincide
            d_reg <= lag_zero ? w_next : rd_val;
        end
        if (cmd.load_out)
        begin
            result_reg <= res_next;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/core/sacd_dpath.sv */
// Datapath: config registers, pointer arithmetic, fill count, both channels.
`include "stereo_comb_allpass_delay_unit_defines.svh"

module sacd_dpath
    import sacd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  sacd_cmd_t                 cmd,
    input  logic                      cfg_we,
    input  logic        [CfgAddrW-1:0] cfg_addr,
    input  logic        [CfgW-1:0]    cfg_wdata,
    input  logic signed [SampleW-1:0] left_sample,
    input  logic signed [SampleW-1:0] right_sample,
    input  logic signed [SampleW-1:0] left_accumulate,
    input  logic signed [SampleW-1:0] right_accumulate,
    output logic signed [SampleW-1:0] left_result,
    output logic signed [SampleW-1:0] right_result
);

    logic             mode_reg;
    logic [DlenW-1:0] dlen_reg;
    logic [LagW-1:0]  lagc_reg;
    logic [GainW-1:0] gain_reg;

    logic [AddrW-1:0] wp_reg;
    logic [LenW-1:0]  fill_reg;
    logic [LenW-1:0]  len_reg;
    logic [AddrW-1:0] lag_reg;
    logic [AddrW-1:0] wp_eff_reg;
    logic [AddrW-1:0] rp_reg;
    logic             lag_zero_reg;

    logic [LenW-1:0]  len_c;
    logic [AddrW-1:0] lag_c;
    logic [AddrW-1:0] wp_c;
    logic [LenW-1:0]  wp_inc;
    logic [LenW-1:0]  rp_c;
    logic             rd_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            dlen_reg <= DlenW'(MaxDelay);
            lagc_reg <= '0;
            gain_reg <= GainW'(16384);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_FILTER_MODE:   mode_reg <= cfg_wdata[0];
                CFG_DELAY_LENGTH:  dlen_reg <= cfg_wdata[DlenW-1:0];
                CFG_READ_LAG:      lagc_reg <= cfg_wdata[LagW-1:0];
                CFG_FEEDBACK_GAIN: gain_reg <= cfg_wdata[GainW-1:0];
                default:           ;
            endcase
        end
    end

    // length clamped to 1..MaxDelay, lag below length, stale pointer to zero
    always_comb
    begin
        if (dlen_reg == '0)
        begin
            len_c = LenW'(1);
        end
        else if (int'(dlen_reg) > MaxDelay)
        begin
            len_c = LenW'(MaxDelay);
        end
        else
        begin
            len_c = LenW'(dlen_reg);
        end
        if (int'(lagc_reg) >= int'(len_c))
        begin
            lag_c = AddrW'(len_c - LenW'(1));
        end
        else
        begin
            lag_c = AddrW'(lagc_reg);
        end
        wp_c = (LenW'(wp_reg) >= len_c) ? '0 : wp_reg;
    end

    assign rp_c = (wp_eff_reg >= lag_reg)
                ? LenW'(wp_eff_reg) - LenW'(lag_reg)
                : LenW'(wp_eff_reg) + len_reg - LenW'(lag_reg);
    assign wp_inc = LenW'(wp_eff_reg) + LenW'(1);
    assign rd_hit = LenW'(rp_reg) < fill_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            len_reg    <= len_c;
            lag_reg    <= lag_c;
            wp_eff_reg <= wp_c;
        end
        if (cmd.addr)
        begin
            rp_reg       <= rp_c[AddrW-1:0];
            lag_zero_reg <= (lag_reg == '0);
        end
    end

    // writes always land inside the filled prefix or just past its end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (cmd.addr)
            begin
                wp_reg <= (wp_inc >= len_reg) ? '0 : wp_inc[AddrW-1:0];
            end
            if (cmd.wr && (LenW'(wp_eff_reg) == fill_reg))
            begin
                fill_reg <= fill_reg + LenW'(1);
            end
        end
    end

    sacd_chan u_left
    (
        .clk        (clk),
        .cmd        (cmd),
        .sample     (left_sample),
        .accumulate (left_accumulate),
        .gain       (gain_reg),
        .allpass    (mode_reg),
        .rd_addr    (rp_reg),
        .wr_addr    (wp_eff_reg),
        .rd_hit     (rd_hit),
        .lag_zero   (lag_zero_reg),
        .result     (left_result)
    );

    sacd_chan u_right
    (
        .clk        (clk),
        .cmd        (cmd),
        .sample     (right_sample),
        .accumulate (right_accumulate),
        .gain       (gain_reg),
        .allpass    (mode_reg),
        .rd_addr    (rp_reg),
        .wr_addr    (wp_eff_reg),
        .rd_hit     (rd_hit),
        .lag_zero   (lag_zero_reg),
        .result     (right_result)
    );

    `SACD_ASSERT_IMP(a_write_in_prefix, cmd.wr, LenW'(wp_eff_reg) <= fill_reg, "write beyond filled prefix")
    `SACD_ASSERT_IMP(a_read_in_range, cmd.rd, LenW'(rp_reg) < len_reg, "read pointer beyond length")

endmodule
